// ===== design/scap_pkg.sv =====
// shared types and constants of the sound channel allocator
`default_nettype none
package scap_pkg;

	typedef enum logic [2:0] {
		FN_START  = 3'd0,
		FN_STOP   = 3'd1,
		FN_UNLINK = 3'd2,
		FN_TICK   = 3'd3,
		FN_CLEAR  = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	localparam int DIVIDEND_BITS = 31;
	localparam int DIVISOR_BITS = 16;
	localparam int SAMPLE_BITS = 24;
	localparam int TIC_BITS = 32;

	localparam logic [DIVIDEND_BITS-1:0] TICS_PER_SEC = 31'd35;
	localparam logic [SAMPLE_BITS-1:0] HEADER_SKIP = 24'd32;
	localparam logic [SAMPLE_BITS-1:0] MIN_SAMPLES = 24'd48;

endpackage
`default_nettype wire

// ===== design/sound_channel_allocator_top.sv =====
// sound channel allocator: channel table, scan and commit control
// Usage:
// An item is accepted at a clock edge where start is high and busy is low.
// func selects start, stop by origin, unlink origin, expiry tick or clear all.
// Clear all takes effect at the accept edge and keeps busy low.
// Start, stop, unlink and tick (only while enable is set) scan the channel
// table, held in a memory with a registered read port, one entry per cycle;
// a start runs the serial duration divider alongside the scan.
// An item's duration is set by the scan over the memory port, or by the
// divider when it finishes later.
// Requests that are dropped (disabled, silent, bad header) never raise busy.
// A start or stop result appears on channel, operation, sound_id_res,
// volume_res and pan_res for one cycle with result_strobe high, in the cycle
// in which busy falls; the receiver cannot stall, so results are never held.
// The enable register is written through cfg_we and cfg_wdata; the user must
// do so only while idle; the block does not enforce it. Reset clears enable
// and all active flags; inactive channel memory is unused, so not cleared.
`default_nettype none
module sound_channel_allocator_top import scap_pkg::*; #(
	parameter int NUM_CHANNELS = 32,
	parameter int ORIGIN_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic                   cfg_we,
	input  wire logic                   cfg_wdata,
	input  wire logic [2:0]             func,
	input  wire logic [ORIGIN_BITS-1:0] origin_id,
	input  wire logic [9:0]             sound_id,
	input  wire logic                   singularity,
	input  wire logic [7:0]             priority_req,
	input  wire logic [6:0]             volume,
	input  wire logic signed [7:0]      pan,
	input  wire logic [23:0]            sample_count,
	input  wire logic [15:0]            sample_rate,
	input  wire logic [31:0]            now,
	output logic                        result_strobe,
	output logic [4:0]                  channel,
	output logic                        operation,
	output logic [9:0]                  sound_id_res,
	output logic [6:0]                  volume_res,
	output logic signed [7:0]           pan_res
);

	localparam int IW = $clog2(NUM_CHANNELS);
	localparam int CW = $clog2(NUM_CHANNELS + 1);
	localparam int EW = ORIGIN_BITS + 43;
	localparam int P_POS = ORIGIN_BITS;
	localparam int P_SING = ORIGIN_BITS + 1;
	localparam int P_PRIO = ORIGIN_BITS + 2;
	localparam int P_END = ORIGIN_BITS + 10;

	state_t state_q, state_d;
	logic                    enable_q;
	logic [NUM_CHANNELS-1:0] active_q;
	func_t                   func_q;
	logic [ORIGIN_BITS-1:0]  org_q;
	logic                    sing_q;
	logic [7:0]              prio_q;
	logic [9:0]              snd_q;
	logic [6:0]              vol_q;
	logic [7:0]              pan_q;
	logic [31:0]             now_q;
	logic                    pos_q;

	logic [CW-1:0] cnt_q;
	logic [IW-1:0] rd_addr;
	logic          rv_s1;
	logic [IW-1:0] ra_s1;
	logic [EW-1:0] rd_s1;
	logic [EW-1:0] mem [NUM_CHANNELS];

	logic          hit_found_q, free_found_q;
	logic [IW-1:0] hit_idx_q, free_idx_q, max_idx_q;
	logic [7:0]    max_prio_q;

	logic accept, start_ok, launch, scan_on, commit;
	logic [SAMPLE_BITS-1:0]   body;
	logic [DIVIDEND_BITS-1:0] dividend;
	logic                     div_go, div_busy;
	logic [DIVIDEND_BITS-1:0] quotient;

	logic [ORIGIN_BITS-1:0] e_org;
	logic                   e_pos, e_sing, act_e, expired, org_eq, hit_cond, free_cond;
	logic [7:0]             e_prio;
	logic [32:0]            e_end, end_tic;
	logic                   take;
	logic [IW-1:0]          slot;
	logic                   mem_we;
	logic [IW-1:0]          mem_waddr;
	logic [EW-1:0]          mem_wdata;

	assign accept = start && !busy;
	assign start_ok = sound_id != '0 && volume != '0 && sample_rate != '0 &&
		sample_count > MIN_SAMPLES;
	assign launch = accept && enable_q && ((func == FN_START && start_ok) ||
		func == FN_STOP || func == FN_TICK || (func == FN_UNLINK && origin_id != '0));
	assign div_go = launch && func == FN_START;
	assign body = sample_count - HEADER_SKIP;
	assign dividend = DIVIDEND_BITS'(body) * TICS_PER_SEC +
		DIVIDEND_BITS'(sample_rate) - DIVIDEND_BITS'(1);
	assign pos_q = org_q != '0;
	assign scan_on = state_q == ST_SCAN && cnt_q < CW'(NUM_CHANNELS);
	assign rd_addr = cnt_q[IW-1:0];
	assign commit = state_q == ST_COMMIT;

	scap_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (dividend),
		.divisor  (sample_rate),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (launch) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (cnt_q == CW'(NUM_CHANNELS) && !rv_s1 && !div_busy) state_d = ST_COMMIT;
			end
			ST_COMMIT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_IDLE: busy = 1'b0;
			default: busy = 1'b1;
		endcase
	end

	assign e_org = rd_s1[ORIGIN_BITS-1:0];
	assign e_pos = rd_s1[P_POS];
	assign e_sing = rd_s1[P_SING];
	assign e_prio = rd_s1[P_END-1:P_PRIO];
	assign e_end = rd_s1[EW-1:P_END];
	assign act_e = active_q[ra_s1];
	assign org_eq = e_org == org_q;
	assign expired = {1'b0, now_q} >= e_end;
	assign hit_cond = act_e && org_eq &&
		(func_q == FN_STOP || (e_pos == pos_q && e_sing == sing_q));
	assign free_cond = !act_e || expired;
	assign end_tic = {1'b0, now_q} + 33'(quotient);

	always_comb begin
		take = 1'b0;
		slot = hit_idx_q;
		if (func_q == FN_START) begin
			if (hit_found_q) begin
				take = 1'b1;
			end else if (free_found_q) begin
				take = 1'b1;
				slot = free_idx_q;
			end else if (prio_q <= max_prio_q) begin
				take = 1'b1;
				slot = max_idx_q;
			end
		end else if (func_q == FN_STOP) begin
			take = hit_found_q;
		end
	end

	always_comb begin
		if (commit) begin
			mem_we = take && func_q == FN_START;
			mem_waddr = slot;
			mem_wdata = {end_tic, prio_q, sing_q, pos_q, org_q};
		end else begin
			mem_we = rv_s1 && func_q == FN_UNLINK && act_e && org_eq;
			mem_waddr = ra_s1;
			mem_wdata = {rd_s1[EW-1:ORIGIN_BITS], ORIGIN_BITS'(0)};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (scan_on) rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			enable_q <= 1'b0;
			active_q <= '0;
			cnt_q <= '0;
			rv_s1 <= 1'b0;
			hit_found_q <= 1'b0;
			free_found_q <= 1'b0;
			result_strobe <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1 <= scan_on;
			result_strobe <= commit && take;
			if (cfg_we) enable_q <= cfg_wdata;
			if (accept && func == FN_CLEAR) active_q <= '0;
			if (launch) begin
				cnt_q <= '0;
				hit_found_q <= 1'b0;
				free_found_q <= 1'b0;
			end else if (scan_on) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (rv_s1) begin
				if (hit_cond && !hit_found_q) hit_found_q <= 1'b1;
				if (free_cond && !free_found_q) free_found_q <= 1'b1;
				if (func_q == FN_TICK && act_e && expired) active_q[ra_s1] <= 1'b0;
			end
			if (commit && take) active_q[slot] <= func_q == FN_START;
		end
	end

	always_ff @(posedge clk) begin
		ra_s1 <= rd_addr;
		if (launch) begin
			func_q <= func_t'(func);
			org_q <= origin_id;
			sing_q <= singularity;
			prio_q <= priority_req;
			snd_q <= sound_id;
			vol_q <= volume;
			pan_q <= pan;
			now_q <= now;
		end
		if (rv_s1) begin
			if (hit_cond && !hit_found_q) hit_idx_q <= ra_s1;
			if (free_cond && !free_found_q) free_idx_q <= ra_s1;
			if (ra_s1 == '0 || e_prio > max_prio_q) begin
				max_idx_q <= ra_s1;
				max_prio_q <= e_prio;
			end
		end
		if (commit) begin
			channel <= 5'(slot);
			operation <= func_q == FN_START;
			sound_id_res <= (func_q == FN_START) ? snd_q : '0;
			volume_res <= (func_q == FN_START) ? vol_q : '0;
			pan_res <= (func_q == FN_START) ? pan_q : '0;
		end
	end

endmodule
`default_nettype wire

// ===== design/scap_div.sv =====
// serial restoring divider for the channel duration
`default_nettype none
module scap_div import scap_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     go,
	input  wire logic [DIVIDEND_BITS-1:0] dividend,
	input  wire logic [DIVISOR_BITS-1:0]  divisor,
	output logic                          busy,
	output logic [DIVIDEND_BITS-1:0]      quotient
);

	localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

	logic [CNT_BITS-1:0]      cnt_q;
	logic [DIVISOR_BITS-1:0]  rem_q;
	logic [DIVIDEND_BITS-1:0] quo_q;
	logic [DIVISOR_BITS-1:0]  div_q;
	logic [DIVISOR_BITS:0]    trial;
	logic [DIVISOR_BITS:0]    diff;
	logic                     fits;

	assign trial = {rem_q, quo_q[DIVIDEND_BITS-1]};
	assign diff = trial - {1'b0, div_q};
	assign fits = trial >= {1'b0, div_q};
	assign busy = cnt_q != '0;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= CNT_BITS'(DIVIDEND_BITS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy) begin
			rem_q <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
			quo_q <= {quo_q[DIVIDEND_BITS-2:0], fits};
		end
	end

endmodule
`default_nettype wire

// ===== design/scap_chk.sv =====
// port-level checks of the sound channel allocator and their bind
`default_nettype none
module scap_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              result_strobe,
	input wire logic              operation,
	input wire logic [9:0]        sound_id_res,
	input wire logic [6:0]        volume_res,
	input wire logic signed [7:0] pan_res
);

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> !busy) else $error("result while busy");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe) else $error("back to back results");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("busy without an item");

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !operation |-> sound_id_res == '0 && volume_res == '0 &&
		pan_res == '0) else $error("stop result carries payload");

	a_start_audible: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && operation |-> sound_id_res != '0 && volume_res != '0)
		else $error("silent start result");

endmodule

bind sound_channel_allocator_top scap_chk u_scap_chk (.*);
`default_nettype wire

// ===== tb/scap_checker.sv =====
// checker: tracks accepted items, predicts channel table results and compares them
`default_nettype none
module scap_checker import scap_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire logic              cfg_we,
	input  wire logic              cfg_wdata,
	input  wire logic [2:0]        func,
	input  wire logic [15:0]       origin_id,
	input  wire logic [9:0]        sound_id,
	input  wire logic              singularity,
	input  wire logic [7:0]        priority_req,
	input  wire logic [6:0]        volume,
	input  wire logic signed [7:0] pan,
	input  wire logic [23:0]       sample_count,
	input  wire logic [15:0]       sample_rate,
	input  wire logic [31:0]       now,
	input  wire logic              result_strobe,
	input  wire logic [4:0]        channel,
	input  wire logic              operation,
	input  wire logic [9:0]        sound_id_res,
	input  wire logic [6:0]        volume_res,
	input  wire logic signed [7:0] pan_res,
	output int                     errors,
	output int                     pending
);

	localparam int NCH = 32;

	typedef struct packed {
		logic [4:0]        channel;
		logic              operation;
		logic [9:0]        sound;
		logic [6:0]        level;
		logic signed [7:0] balance;
	} chan_event_t;

	chan_event_t expected_events[$];

	logic        enabled;
	logic        active_q[NCH];
	logic [15:0] origin_q[NCH];
	logic        positioned_q[NCH];
	logic        single_q[NCH];
	logic [7:0]  prio_q[NCH];
	logic [32:0] end_tic_q[NCH];

	assign pending = expected_events.size();

	function automatic void wipe_table();
		for (int i = 0; i < NCH; i++) begin
			active_q[i] = 1'b0;
			origin_q[i] = '0;
			positioned_q[i] = 1'b0;
			single_q[i] = 1'b0;
			prio_q[i] = '0;
			end_tic_q[i] = '0;
		end
	endfunction

	function automatic void allocate_start();
		logic [63:0] dur;
		logic [32:0] end_tic;
		logic        pos;
		int          slot;
		chan_event_t ev;
		pos = origin_id != 0;
		slot = -1;
		if (sound_id == 0 || volume == 0) return;
		if (sample_rate == 0 || sample_count <= MIN_SAMPLES) return;
		dur = ((64'(sample_count) - 64'd32) * 64'd35 + 64'(sample_rate) - 64'd1)
			/ 64'(sample_rate);
		end_tic = 33'(64'(now) + dur);
		for (int i = 0; i < NCH; i++)
			if (slot < 0 && active_q[i] && origin_q[i] == origin_id &&
					positioned_q[i] == pos && single_q[i] == singularity)
				slot = i;
		for (int i = 0; i < NCH; i++)
			if (slot < 0 && (!active_q[i] || {1'b0, now} >= end_tic_q[i]))
				slot = i;
		if (slot < 0) begin
			slot = 0;
			for (int i = 1; i < NCH; i++)
				if (prio_q[i] > prio_q[slot]) slot = i;
			if (priority_req > prio_q[slot]) return;
		end
		active_q[slot] = 1'b1;
		origin_q[slot] = origin_id;
		positioned_q[slot] = pos;
		single_q[slot] = singularity;
		prio_q[slot] = priority_req;
		end_tic_q[slot] = end_tic;
		ev.channel = 5'(slot);
		ev.operation = 1'b1;
		ev.sound = sound_id;
		ev.level = volume;
		ev.balance = pan;
		expected_events.push_back(ev);
	endfunction

	function automatic void predict_item();
		chan_event_t ev;
		bit          done;
		done = 0;
		if (func == FN_CLEAR) begin
			wipe_table();
			return;
		end
		if (!enabled) return;
		case (func)
			FN_START: allocate_start();
			FN_STOP: begin
				for (int i = 0; i < NCH; i++)
					if (!done && active_q[i] && origin_q[i] == origin_id) begin
						active_q[i] = 1'b0;
						ev = '0;
						ev.channel = 5'(i);
						expected_events.push_back(ev);
						done = 1;
					end
			end
			FN_UNLINK: begin
				if (origin_id != 0)
					for (int i = 0; i < NCH; i++)
						if (active_q[i] && origin_q[i] == origin_id) origin_q[i] = '0;
			end
			FN_TICK: begin
				for (int i = 0; i < NCH; i++)
					if (active_q[i] && {1'b0, now} >= end_tic_q[i]) active_q[i] = 1'b0;
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		chan_event_t ev;
		if (!arst_n) begin
			enabled = 1'b0;
			errors = 0;
			expected_events.delete();
			wipe_table();
		end else begin
			if (result_strobe) begin
				if (expected_events.size() == 0) begin
					$error("unexpected result on channel %0d", channel);
					errors++;
				end else begin
					ev = expected_events.pop_front();
					if (channel !== ev.channel) begin
						$error("channel: expected %0d, got %0d", ev.channel, channel);
						errors++;
					end
					if (operation !== ev.operation) begin
						$error("operation: expected %0d, got %0d", ev.operation, operation);
						errors++;
					end
					if (sound_id_res !== ev.sound) begin
						$error("sound_id_res: expected %0d, got %0d", ev.sound, sound_id_res);
						errors++;
					end
					if (volume_res !== ev.level) begin
						$error("volume_res: expected %0d, got %0d", ev.level, volume_res);
						errors++;
					end
					if (pan_res !== ev.balance) begin
						$error("pan_res: expected %0d, got %0d", ev.balance, pan_res);
						errors++;
					end
				end
			end
			if (cfg_we) enabled = cfg_wdata;
			if (start && !busy) predict_item();
		end
	end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// testbench top: drives requests and configuration into the allocator, gives the verdict
`default_nettype none
module testbench import scap_pkg::*;;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              cfg_we = 1'b0;
	logic              cfg_wdata = 1'b0;
	logic [2:0]        func = FN_TICK;
	logic [15:0]       origin_id = '0;
	logic [9:0]        sound_id = '0;
	logic              singularity = 1'b0;
	logic [7:0]        priority_req = '0;
	logic [6:0]        volume = '0;
	logic signed [7:0] pan = '0;
	logic [23:0]       sample_count = '0;
	logic [15:0]       sample_rate = '0;
	logic [31:0]       now = '0;
	logic              result_strobe;
	logic [4:0]        channel;
	logic              operation;
	logic [9:0]        sound_id_res;
	logic [6:0]        volume_res;
	logic signed [7:0] pan_res;
	int                errors;
	int                pending;

	logic [31:0] game_tic;
	int          idle_pct;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	sound_channel_allocator_top i_dut (
		.clk, .arst_n, .start, .busy, .cfg_we, .cfg_wdata, .func, .origin_id,
		.sound_id, .singularity, .priority_req, .volume, .pan, .sample_count,
		.sample_rate, .now, .result_strobe, .channel, .operation, .sound_id_res,
		.volume_res, .pan_res
	);

	scap_checker i_checker (
		.clk, .arst_n, .start, .busy, .cfg_we, .cfg_wdata, .func, .origin_id,
		.sound_id, .singularity, .priority_req, .volume, .pan, .sample_count,
		.sample_rate, .now, .result_strobe, .channel, .operation, .sound_id_res,
		.volume_res, .pan_res, .errors, .pending
	);

	initial begin
		#20_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	task automatic issue(input logic [2:0] f, input logic [15:0] org, input logic [9:0] snd,
			input logic sing, input logic [7:0] prio, input logic [6:0] vol,
			input logic [7:0] pn, input logic [23:0] smp, input logic [15:0] rate,
			input logic [31:0] tic);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		func <= f;
		origin_id <= org;
		sound_id <= snd;
		singularity <= sing;
		priority_req <= prio;
		volume <= vol;
		pan <= pn;
		sample_count <= smp;
		sample_rate <= rate;
		now <= tic;
		do @(posedge clk); while (busy);
	endtask

	// drain outstanding results, let the block settle, then write enable
	task automatic write_enable(input logic value);
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_item();
		logic [2:0]  f;
		logic [15:0] org;
		logic [9:0]  snd;
		logic [6:0]  vol;
		logic [7:0]  pn;
		logic [23:0] smp;
		logic [15:0] rate;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 58) f = FN_START;
		else if (pick < 73) f = FN_STOP;
		else if (pick < 81) f = FN_UNLINK;
		else if (pick < 95) f = FN_TICK;
		else if (pick < 96) f = FN_CLEAR;
		else f = 3'($urandom_range(5, 7));
		org = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
		snd = ($urandom_range(29) == 0) ? 10'd0 : 10'($urandom_range(1, 1023));
		vol = ($urandom_range(29) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
		pn = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 192) - 96);
		pick = $urandom_range(19);
		smp = (pick == 0) ? 24'($urandom) : (pick == 1) ? 24'($urandom_range(0, 49))
			: 24'($urandom_range(49, 3000));
		pick = $urandom_range(19);
		rate = (pick == 0) ? 16'($urandom) : (pick == 1) ? 16'($urandom_range(0, 3))
			: 16'($urandom_range(1000, 22050));
		if ($urandom_range(199) == 0) game_tic = 32'hFFFF_FFFF - 32'($urandom_range(0, 300));
		else game_tic = game_tic + 32'($urandom_range(0, 3));
		issue(f, org, snd, 1'($urandom), 8'($urandom), vol, pn, smp, rate, game_tic);
	endtask

	initial begin
		game_tic = 32'd100;
		idle_pct = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// disabled: starts ignored, clear still taken
		issue(FN_START, 16'd1, 10'd5, 1'b0, 8'd10, 7'd64, 8'd0, 24'd1000, 16'd11025, 32'd0);
		issue(FN_CLEAR, 16'd0, 10'd0, 1'b0, 8'd0, 7'd0, 8'd0, 24'd0, 16'd0, 32'd0);
		write_enable(1'b1);
		issue(FN_START, 16'hFFFF, 10'h3FF, 1'b1, 8'hFF, 7'h7F, 8'sd96, 24'hFFFFFF,
			16'hFFFF, 32'hFFFF_FFFF);
		issue(FN_START, 16'd0, 10'd1, 1'b0, 8'd0, 7'd1, -8'sd96, 24'd49, 16'd1, 32'd0);
		issue(FN_START, 16'd2, 10'd0, 1'b0, 8'd5, 7'd9, 8'd0, 24'd1000, 16'd8000, 32'd10);
		issue(FN_START, 16'd2, 10'd7, 1'b0, 8'd5, 7'd0, 8'd0, 24'd1000, 16'd8000, 32'd10);
		issue(FN_START, 16'd2, 10'd7, 1'b0, 8'd5, 7'd9, 8'd0, 24'd1000, 16'd0, 32'd10);
		issue(FN_START, 16'd2, 10'd7, 1'b0, 8'd5, 7'd9, 8'd0, 24'd48, 16'd8000, 32'd10);
		issue(FN_START, 16'd2, 10'd7, 1'b0, 8'd5, 7'd9, 8'd3, 24'd1000, 16'd8000, 32'd10);
		issue(FN_START, 16'd2, 10'd8, 1'b0, 8'd5, 7'd19, 8'd4, 24'd900, 16'd8000, 32'd11);
		issue(FN_STOP, 16'd0, 10'd0, 1'b0, 8'd0, 7'd0, 8'd0, 24'd0, 16'd0, 32'd11);
		issue(FN_UNLINK, 16'd0, 10'd0, 1'b0, 8'd0, 7'd0, 8'd0, 24'd0, 16'd0, 32'd11);
		issue(FN_UNLINK, 16'd2, 10'd0, 1'b0, 8'd0, 7'd0, 8'd0, 24'd0, 16'd0, 32'd11);
		issue(FN_STOP, 16'd0, 10'd0, 1'b0, 8'd0, 7'd0, 8'd0, 24'd0, 16'd0, 32'd11);
		issue(FN_TICK, 16'd0, 10'd0, 1'b0, 8'd0, 7'd0, 8'd0, 24'd0, 16'd0, 32'd12);
		issue(FN_TICK, 16'd0, 10'd0, 1'b0, 8'd0, 7'd0, 8'd0, 24'd0, 16'd0, 32'd5000);
		issue(3'd5, 16'd0, 10'd0, 1'b0, 8'd0, 7'd0, 8'd0, 24'd0, 16'd0, 32'd0);
		issue(3'd7, 16'hFFFF, 10'h3FF, 1'b1, 8'hFF, 7'h7F, 8'hFF, 24'hFFFFFF, 16'hFFFF,
			32'hFFFF_FFFF);
		// fill every slot, then a priority loss and a priority replacement
		for (int i = 0; i < 33; i++)
			issue(FN_START, 16'(100 + i), 10'(i + 1), 1'b0, 8'(i + 50), 7'd20, 8'd0,
				24'd60000, 16'd1000, 32'd6000);
		issue(FN_START, 16'd300, 10'd99, 1'b0, 8'd255, 7'd20, 8'd0, 24'd60000, 16'd1000,
			32'd6000);
		issue(FN_START, 16'd301, 10'd98, 1'b1, 8'd1, 7'd20, 8'd0, 24'd60000, 16'd1000,
			32'd6000);
		issue(FN_CLEAR, 16'd0, 10'd0, 1'b0, 8'd0, 7'd0, 8'd0, 24'd0, 16'd0, 32'd0);

		repeat (500) random_item();
		write_enable(1'b1);
		idle_pct = 62;
		repeat (450) random_item();
		write_enable(1'b0);
		idle_pct = 24;
		repeat (100) random_item();
		write_enable(1'b1);
		repeat (650) random_item();

		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
